// ===== hw/rtl/yuyvrgb_pkg.sv =====
// ----------------------------------------------------------------------------
// yuyvrgb_pkg
// Item types, register indexes and conversion tables for the YUYV to RGB888
// converter.
// ----------------------------------------------------------------------------
package yuyvrgb_pkg;

    // One YUYV macropixel
    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] chroma_blue;
        logic [7:0] luma_second;
        logic [7:0] chroma_red;
    } yuyv_item_t;

    // Two RGB888 pixels plus position marks
    typedef struct packed {
        logic [7:0] red_first;
        logic [7:0] green_first;
        logic [7:0] blue_first;
        logic [7:0] red_second;
        logic [7:0] green_second;
        logic [7:0] blue_second;
        logic       line_end;
        logic       frame_end;
    } rgb_item_t;

    typedef logic signed [8:0] term_t;

    // Chroma contributions shared by both pixels of a pair
    typedef struct packed {
        term_t red_add;
        term_t green_sub;
        term_t blue_add;
    } chroma_terms_t;

    typedef struct packed {
        logic line_end;
        logic frame_end;
    } pos_flags_t;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;
    localparam logic [CFG_INDEX_W-1:0] REG_PAIRS_PER_LINE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LINES_PER_FRAME = 2'd1;

    localparam int PPL_W      = 12;
    localparam int LPF_W      = 13;
    localparam int COL_W      = 11;
    localparam int ROW_W      = 12;
    localparam int MAX_PAIRS  = 2048;
    localparam int MAX_LINES  = 4096;
    localparam logic [PPL_W-1:0] PPL_RESET = 12'd400;
    localparam logic [LPF_W-1:0] LPF_RESET = 13'd600;

    // All chroma factors expressed over one denominator
    localparam int CHROMA_DEN = 10000;
    localparam int KBB_NUM    = 17790;
    localparam int KBG_NUM    = 3455;
    localparam int KCG_NUM    = 7169;
    localparam int KCR_NUM    = 14075;

    typedef logic [7:0] luma_tbl_t [256];
    typedef term_t      term_tbl_t [256];

    function automatic luma_tbl_t build_luma_tbl();
        luma_tbl_t t;
        int        v;
        for (int i = 0; i < 256; i++) begin
            v = (i * 6) / 5;
            t[i] = (v > 255) ? 8'd255 : 8'(v);
        end
        return t;
    endfunction

    // Truncate toward zero
    function automatic int scaled_term(int d, int num);
        if (d < 0)
            return -(((-d) * num) / CHROMA_DEN);
        return (d * num) / CHROMA_DEN;
    endfunction

    function automatic term_tbl_t build_term_tbl(int num);
        term_tbl_t t;
        for (int i = 0; i < 256; i++)
            t[i] = term_t'(scaled_term(i - 128, num));
        return t;
    endfunction

    localparam luma_tbl_t LUMA_TBL = build_luma_tbl();
    localparam term_tbl_t KBB_TBL  = build_term_tbl(KBB_NUM);
    localparam term_tbl_t KBG_TBL  = build_term_tbl(KBG_NUM);
    localparam term_tbl_t KCG_TBL  = build_term_tbl(KCG_NUM);
    localparam term_tbl_t KCR_TBL  = build_term_tbl(KCR_NUM);

    function automatic logic [7:0] clamp_byte(logic signed [9:0] v);
        if (v < 10'sd0)
            return 8'd0;
        if (v > 10'sd255)
            return 8'd255;
        return v[7:0];
    endfunction

endpackage

// ===== hw/rtl/yuyvrgb_lookup.sv =====
// ----------------------------------------------------------------------------
// yuyvrgb_lookup
// Table lookups for boosted luma of both pixels and the shared chroma terms.
// ----------------------------------------------------------------------------
module yuyvrgb_lookup
    import yuyvrgb_pkg::*;
(
    input  yuyv_item_t    item,
    output logic [7:0]    luma_first,
    output logic [7:0]    luma_second,
    output chroma_terms_t terms
);

    term_t kbg;
    term_t kcg;

    assign luma_first  = LUMA_TBL[item.luma_first];
    assign luma_second = LUMA_TBL[item.luma_second];

    assign kbg = KBG_TBL[item.chroma_blue];
    assign kcg = KCG_TBL[item.chroma_red];

    // Both green terms together stay within 9 bits
    assign terms.green_sub = kbg + kcg;
    assign terms.red_add   = KCR_TBL[item.chroma_red];
    assign terms.blue_add  = KBB_TBL[item.chroma_blue];

endmodule

// ===== hw/rtl/yuyvrgb_lane.sv =====
// ----------------------------------------------------------------------------
// yuyvrgb_lane
// One pixel lane: add chroma terms to boosted luma and clamp each channel.
// ----------------------------------------------------------------------------
module yuyvrgb_lane
    import yuyvrgb_pkg::*;
(
    input  logic [7:0]    luma,
    input  chroma_terms_t terms,
    output logic [7:0]    red,
    output logic [7:0]    green,
    output logic [7:0]    blue
);

    logic signed [9:0] luma_ext;
    logic signed [9:0] red_sum;
    logic signed [9:0] green_sum;
    logic signed [9:0] blue_sum;

    assign luma_ext  = $signed({2'b00, luma});
    assign red_sum   = luma_ext + $signed({terms.red_add[8], terms.red_add});
    assign green_sum = luma_ext - $signed({terms.green_sub[8], terms.green_sub});
    assign blue_sum  = luma_ext + $signed({terms.blue_add[8], terms.blue_add});

    assign red   = clamp_byte(red_sum);
    assign green = clamp_byte(green_sum);
    assign blue  = clamp_byte(blue_sum);

endmodule

// ===== hw/rtl/yuyvrgb_pos.sv =====
// ----------------------------------------------------------------------------
// yuyvrgb_pos
// Line and frame size registers with the pair column and line row counters.
// ----------------------------------------------------------------------------
module yuyvrgb_pos
    import yuyvrgb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   advance,
    output pos_flags_t             flags
);

    logic [PPL_W-1:0] ppl_reg;
    logic [LPF_W-1:0] lpf_reg;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [COL_W-1:0] col_last;
    logic [ROW_W-1:0] row_last;

    // Zero acts as one, oversized values saturate at the maximum
    always_comb
    begin
        if (ppl_reg == '0)
            col_last = '0;
        else if (ppl_reg > PPL_W'(MAX_PAIRS))
            col_last = COL_W'(MAX_PAIRS - 1);
        else
            col_last = COL_W'(ppl_reg - 1'b1);

        if (lpf_reg == '0)
            row_last = '0;
        else if (lpf_reg > LPF_W'(MAX_LINES))
            row_last = ROW_W'(MAX_LINES - 1);
        else
            row_last = ROW_W'(lpf_reg - 1'b1);
    end

    assign flags.line_end  = (col_reg >= col_last);
    assign flags.frame_end = flags.line_end && (row_reg >= row_last);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (advance) begin
            if (flags.line_end) begin
                col_next = '0;
                row_next = flags.frame_end ? '0 : row_reg + 1'b1;
            end
            else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ppl_reg <= PPL_RESET;
            lpf_reg <= LPF_RESET;
            col_reg <= '0;
            row_reg <= '0;
        end
        else begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (cfg_write) begin
                unique case (cfg_index)
                    REG_PAIRS_PER_LINE:  ppl_reg <= cfg_data[PPL_W-1:0];
                    REG_LINES_PER_FRAME: lpf_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== hw/rtl/yuyv_to_rgb888_converter.sv =====
// Path: an accepted YUYV item is registered after the table lookup stage,
// then the two pixel lanes are merged into the output register.
// Throughput: one item per cycle while rgb_stall does not hold the output.
// Reset: rst_n clears valids and position counters and loads 400 pairs per
// line and 600 lines per frame; the configuration port is always ready.
// ----------------------------------------------------------------------------
// yuyv_to_rgb888_converter
// Converts YUYV macropixels into pairs of RGB888 pixels with line and frame
// end marks.
// ----------------------------------------------------------------------------
module yuyv_to_rgb888_converter
    import yuyvrgb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   yuyv_valid,
    output logic                   yuyv_stall,
    input  yuyv_item_t             yuyv,
    output logic                   rgb_valid,
    input  logic                   rgb_stall,
    output rgb_item_t              rgb
);

    logic          accept;
    logic          s1_load;
    logic          out_load;
    logic          s1_valid_reg;
    logic          s1_valid_next;
    logic          rgb_valid_reg;
    logic          rgb_valid_next;
    logic [7:0]    look_luma0;
    logic [7:0]    look_luma1;
    chroma_terms_t look_terms;
    pos_flags_t    pos_flags;
    logic [7:0]    s1_luma0_reg;
    logic [7:0]    s1_luma1_reg;
    chroma_terms_t s1_terms_reg;
    pos_flags_t    s1_flags_reg;
    rgb_item_t     rgb_reg;
    rgb_item_t     rgb_next;

    assign cfg_ready = 1'b1;

    // Advance each stage when the one after it is empty or moving
    assign out_load   = !rgb_valid_reg || !rgb_stall;
    assign s1_load    = !s1_valid_reg || out_load;
    assign yuyv_stall = !s1_load;
    assign accept     = yuyv_valid && s1_load;

    yuyvrgb_lookup u_lookup (
        .item        (yuyv),
        .luma_first  (look_luma0),
        .luma_second (look_luma1),
        .terms       (look_terms)
    );

    yuyvrgb_pos u_pos (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (accept),
        .flags     (pos_flags)
    );

    yuyvrgb_lane u_lane_first (
        .luma  (s1_luma0_reg),
        .terms (s1_terms_reg),
        .red   (rgb_next.red_first),
        .green (rgb_next.green_first),
        .blue  (rgb_next.blue_first)
    );

    yuyvrgb_lane u_lane_second (
        .luma  (s1_luma1_reg),
        .terms (s1_terms_reg),
        .red   (rgb_next.red_second),
        .green (rgb_next.green_second),
        .blue  (rgb_next.blue_second)
    );

    assign rgb_next.line_end  = s1_flags_reg.line_end;
    assign rgb_next.frame_end = s1_flags_reg.frame_end;

    assign s1_valid_next  = s1_load ? accept : s1_valid_reg;
    assign rgb_valid_next = out_load ? s1_valid_reg : rgb_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            rgb_valid_reg <= 1'b0;
        end
        else begin
            s1_valid_reg  <= s1_valid_next;
            rgb_valid_reg <= rgb_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            s1_luma0_reg <= look_luma0;
            s1_luma1_reg <= look_luma1;
            s1_terms_reg <= look_terms;
            s1_flags_reg <= pos_flags;
        end
        // Hold the result while it is stalled
        if (out_load && s1_valid_reg)
            rgb_reg <= rgb_next;
    end

    assign rgb_valid = rgb_valid_reg;
    assign rgb       = rgb_reg;

endmodule
